>>> rtl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types and constants for the waypoint heading follower.
// ----------------------------------------------------------------------------
`default_nettype none

package wpf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int POS_W      = 24;
    localparam int ANG_W      = 16;
    localparam int SPD_W      = 16;
    localparam int LEFT_W     = 7;
    localparam int DSQ_W      = 51;
    localparam int TOL_W      = 15;
    localparam int RATE_W     = 15;
    localparam int ERR_W      = 18;
    localparam int CFG_DATA_W = 51;
    localparam int CFG_IDX_W  = 3;
    localparam int CMD_W      = 2;
    localparam int WP_W       = 2 * POS_W + ANG_W;
    localparam int OUT_W      = 2 * SPD_W + LEFT_W + 1;

    // Q2.13 pi and 2*pi
    localparam logic signed [ERR_W-1:0] ANG_PI     = 18'sd25736;
    localparam logic signed [ERR_W-1:0] ANG_TWO_PI = 18'sd51472;

    localparam logic [DSQ_W-1:0]  RST_ARRIVE_DIST_SQ = 51'd167772;
    localparam logic [TOL_W-1:0]  RST_ANGLE_TOL      = 15'd82;
    localparam logic [RATE_W-1:0] RST_TURN_RATE      = 15'd43;
    localparam logic [SPD_W-1:0]  RST_CRUISE_SPEED   = 16'd256;
    localparam logic [SPD_W-1:0]  RST_ALIGNED_SPEED  = 16'd13;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRIVE_DIST_SQ = 3'd0,
        CFG_ANGLE_TOL      = 3'd1,
        CFG_TURN_RATE      = 3'd2,
        CFG_CRUISE_SPEED   = 3'd3,
        CFG_ALIGNED_SPEED  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ANG_W-1:0] heading;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } t_waypoint;

endpackage

`default_nettype wire

>>> rtl/waypoint_heading_follower.sv
// ----------------------------------------------------------------------------
// waypoint_heading_follower
// Waypoint queue with bang-bang heading control on each pose tick.
// ----------------------------------------------------------------------------
// One transaction per clock is sustained while the output is not stalled. A
// transaction is captured in an input register and processed in the next
// cycle (queue update, squared distance compare, heading error wrap). Its
// result, if any, is written to the output register at the next edge. A
// result held by a stalled output holds the input register, and so the input.
// The head waypoint is kept in a register that is refreshed from the 64-entry
// queue memory every cycle, with a bypass when an append lands on the head
// slot, so consecutive ticks and appends run at full rate. Clear and append
// give no result; a tick gives none before any path command or when the head
// waypoint is reached.
`default_nettype none

module waypoint_heading_follower (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [50:0] i_cfg_data,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // pos_x[23:0], pos_y[47:24], heading[63:48]
    input  wire logic [1:0]  i_s_axis_tuser,  // command[1:0]
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata   // linear_speed[15:0], angular_rate[31:16],
                                              // waypoints_left[38:32], overflow[39]
);

    localparam int IDX_W = wpf_pkg::IDX_W;
    localparam int CNT_W = wpf_pkg::CNT_W;

    // configuration
    logic [wpf_pkg::DSQ_W-1:0]  r_arrive_dist_sq;
    logic [wpf_pkg::TOL_W-1:0]  r_angle_tol;
    logic [wpf_pkg::RATE_W-1:0] r_turn_rate;
    logic [wpf_pkg::SPD_W-1:0]  r_cruise_speed;
    logic [wpf_pkg::SPD_W-1:0]  r_aligned_speed;

    // input stage
    logic               r_in_valid;
    wpf_pkg::t_cmd      r_in_cmd;
    wpf_pkg::t_waypoint r_in_wp;

    // queue state
    logic [wpf_pkg::WP_W-1:0] r_mem [wpf_pkg::QUEUE_DEPTH];
    wpf_pkg::t_waypoint       r_head_wp;
    logic [IDX_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_count;
    logic                     r_path;
    logic                     r_ovf;
    logic [IDX_W-1:0]         n_head;
    logic [CNT_W-1:0]         n_count;
    logic                     n_path;
    logic                     n_ovf;

    // output stage
    logic                                r_out_valid;
    logic [wpf_pkg::SPD_W-1:0]           r_out_lin;
    logic signed [wpf_pkg::SPD_W-1:0]    r_out_ang;
    logic [wpf_pkg::LEFT_W-1:0]          r_out_left;
    logic                                r_out_ovf;

    logic                                w_out_free;
    logic                                w_adv;
    logic                                w_fire;
    logic                                w_has_result;
    logic                                w_we;
    logic [wpf_pkg::SPD_W-1:0]           w_lin;
    logic signed [wpf_pkg::SPD_W-1:0]    w_ang;
    logic [CNT_W:0]                      w_slot_sum;
    logic [IDX_W-1:0]                    w_slot;
    logic [IDX_W-1:0]                    w_head_inc;
    logic [IDX_W-1:0]                    w_rd_addr;

    logic signed [wpf_pkg::POS_W:0]      w_dx;
    logic signed [wpf_pkg::POS_W:0]      w_dy;
    logic [wpf_pkg::POS_W-1:0]           w_abs_x;
    logic [wpf_pkg::POS_W-1:0]           w_abs_y;
    logic [2*wpf_pkg::POS_W-1:0]         w_sq_x;
    logic [2*wpf_pkg::POS_W-1:0]         w_sq_y;
    logic [2*wpf_pkg::POS_W:0]           w_dsq;
    logic                                w_arrive;
    logic signed [wpf_pkg::ERR_W-1:0]    w_err0;
    logic signed [wpf_pkg::ERR_W-1:0]    w_err1;
    logic signed [wpf_pkg::ERR_W-1:0]    w_err2;
    logic signed [wpf_pkg::ERR_W-1:0]    w_tol;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive_dist_sq <= wpf_pkg::RST_ARRIVE_DIST_SQ;
            r_angle_tol      <= wpf_pkg::RST_ANGLE_TOL;
            r_turn_rate      <= wpf_pkg::RST_TURN_RATE;
            r_cruise_speed   <= wpf_pkg::RST_CRUISE_SPEED;
            r_aligned_speed  <= wpf_pkg::RST_ALIGNED_SPEED;
        end else if (i_cfg_we) begin
            case (wpf_pkg::t_cfg_idx'(i_cfg_index))
                wpf_pkg::CFG_ARRIVE_DIST_SQ: r_arrive_dist_sq <= i_cfg_data;
                wpf_pkg::CFG_ANGLE_TOL:      r_angle_tol      <= i_cfg_data[wpf_pkg::TOL_W-1:0];
                wpf_pkg::CFG_TURN_RATE:      r_turn_rate      <= i_cfg_data[wpf_pkg::RATE_W-1:0];
                wpf_pkg::CFG_CRUISE_SPEED:   r_cruise_speed   <= i_cfg_data[wpf_pkg::SPD_W-1:0];
                wpf_pkg::CFG_ALIGNED_SPEED:  r_aligned_speed  <= i_cfg_data[wpf_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = !w_has_result || w_out_free;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd <= wpf_pkg::t_cmd'(i_s_axis_tuser);
            r_in_wp  <= wpf_pkg::t_waypoint'(i_s_axis_tdata);
        end
    end

    // ---------------- datapath ----------------
    assign w_dx    = (wpf_pkg::POS_W+1)'(r_in_wp.pos_x) - (wpf_pkg::POS_W+1)'(r_head_wp.pos_x);
    assign w_dy    = (wpf_pkg::POS_W+1)'(r_in_wp.pos_y) - (wpf_pkg::POS_W+1)'(r_head_wp.pos_y);
    assign w_abs_x = wpf_pkg::POS_W'(w_dx[wpf_pkg::POS_W] ? -w_dx : w_dx);
    assign w_abs_y = wpf_pkg::POS_W'(w_dy[wpf_pkg::POS_W] ? -w_dy : w_dy);
    assign w_sq_x  = (2*wpf_pkg::POS_W)'(w_abs_x) * (2*wpf_pkg::POS_W)'(w_abs_x);
    assign w_sq_y  = (2*wpf_pkg::POS_W)'(w_abs_y) * (2*wpf_pkg::POS_W)'(w_abs_y);
    assign w_dsq   = (2*wpf_pkg::POS_W+1)'(w_sq_x) + (2*wpf_pkg::POS_W+1)'(w_sq_y);
    assign w_arrive = wpf_pkg::DSQ_W'(w_dsq) <= r_arrive_dist_sq;

    // yaw minus target, wrapped once toward +-pi
    assign w_err0 = wpf_pkg::ERR_W'(r_in_wp.heading) - wpf_pkg::ERR_W'(r_head_wp.heading);
    assign w_err1 = (w_err0 > wpf_pkg::ANG_PI) ? w_err0 - wpf_pkg::ANG_TWO_PI : w_err0;
    assign w_err2 = (w_err1 < -wpf_pkg::ANG_PI) ? w_err1 + wpf_pkg::ANG_TWO_PI : w_err1;
    assign w_tol  = signed'({{(wpf_pkg::ERR_W-wpf_pkg::TOL_W){1'b0}}, r_angle_tol});

    assign w_slot_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign w_slot     = IDX_W'((w_slot_sum >= (CNT_W+1)'(wpf_pkg::QUEUE_DEPTH))
                               ? w_slot_sum - (CNT_W+1)'(wpf_pkg::QUEUE_DEPTH) : w_slot_sum);
    assign w_head_inc = (r_head == IDX_W'(wpf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_path       = r_path;
        n_ovf        = r_ovf;
        w_we         = 1'b0;
        w_has_result = 1'b0;
        w_lin        = '0;
        w_ang        = '0;
        if (r_in_valid) begin
            case (r_in_cmd)
                wpf_pkg::CMD_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                    n_path  = 1'b1;
                end
                wpf_pkg::CMD_APPEND: begin
                    n_path = 1'b1;
                    if (r_count == CNT_W'(wpf_pkg::QUEUE_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                wpf_pkg::CMD_TICK: begin
                    if (r_path) begin
                        if (r_count != '0 && w_arrive) begin
                            n_head  = w_head_inc;
                            n_count = r_count - 1'b1;
                        end else begin
                            w_has_result = 1'b1;
                            if (r_count != '0) begin
                                if (w_err2 > w_tol) begin
                                    w_lin = r_cruise_speed;
                                    w_ang = -signed'({1'b0, r_turn_rate});
                                end else if (w_err2 < -w_tol) begin
                                    w_lin = r_cruise_speed;
                                    w_ang = signed'({1'b0, r_turn_rate});
                                end else begin
                                    w_lin = r_aligned_speed;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- queue state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_path  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_fire) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_path  <= n_path;
            r_ovf   <= n_ovf;
        end
    end

    assign w_rd_addr = w_fire ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (w_fire && w_we) begin
            r_mem[w_slot] <= r_in_wp;
        end
    end

    // head register, bypassing an append into the head slot
    always_ff @(posedge i_clk) begin
        if (w_fire && w_we && (w_slot == w_rd_addr)) begin
            r_head_wp <= r_in_wp;
        end else begin
            r_head_wp <= wpf_pkg::t_waypoint'(r_mem[w_rd_addr]);
        end
    end

    // ---------------- output stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            r_out_lin  <= w_lin;
            r_out_ang  <= w_ang;
            r_out_left <= wpf_pkg::LEFT_W'(r_count);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ovf, r_out_left, r_out_ang, r_out_lin};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(wpf_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd == wpf_pkg::CMD_APPEND
         && r_count != CNT_W'(wpf_pkg::QUEUE_DEPTH))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not grow the queue");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_left == '0) |-> (r_out_lin == '0 && r_out_ang == '0))
        else $error("nonzero speed with empty queue");

    a_no_result_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_count != '0 && n_count == r_count - 1'b1) |-> !w_has_result)
        else $error("result emitted on arrival");

endmodule

`default_nettype wire
